// ===== rtl/arc_pkg.sv =====
// Shared definitions for the address resolution cache.
// Table geometry, operation and status codes, controller command struct.
// No dependencies.
package arc_pkg;

	localparam int ENTRIES   = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int COUNT_MAX = 31;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic capture;
		logic exec;
	} arc_cmd_t;

	// clamp the internal count to the 5-bit result field
	function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+4:0] wide;
		wide = {5'b0, c};
		if (wide > (CNT_W+5)'(COUNT_MAX))
			return 5'(COUNT_MAX);
		else
			return wide[4:0];
	endfunction

endpackage

// ===== rtl/arc_ctrl.sv =====
// Controller for the address resolution cache.
// Two-state sequencer: capture a transaction, execute it, raise done.
// Depends on arc_pkg.
module arc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output arc_pkg::arc_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q == S_EXEC);
	assign done        = done_q;
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EXEC))
		else $error("done without a preceding execute cycle");

	a_capture_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (cmd.exec && !cmd.capture))
		else $error("captured transaction not executed");

	a_busy_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

endmodule

// ===== rtl/arc_datapath.sv =====
// Datapath for the address resolution cache.
// Holds the binding table, parallel key compare, first-free encoder, result registers.
// Depends on arc_pkg.
module arc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  arc_pkg::arc_cmd_t cmd,
	input  logic [1:0]        func,
	input  logic [31:0]       ip_addr,
	input  logic [47:0]       new_mac,
	output logic [1:0]        status,
	output logic [47:0]       found_mac,
	output logic [4:0]        valid_count
);

	logic [1:0]  func_s1;
	logic [31:0] ip_s1;
	logic [47:0] mac_s1;

	logic [arc_pkg::ENTRIES-1:0]     valid_q;
	logic [31:0]                     ip_q  [arc_pkg::ENTRIES];
	logic [47:0]                     mac_q [arc_pkg::ENTRIES];
	logic [arc_pkg::CNT_W-1:0]       count_q;
	logic [1:0]                      status_q;
	logic [47:0]                     found_q;

	logic [arc_pkg::ENTRIES-1:0] hit;
	logic                        hit_any;
	logic                        free_any;
	logic [arc_pkg::IDX_W-1:0]   hit_idx;
	logic [arc_pkg::IDX_W-1:0]   free_idx;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_s1 <= func;
			ip_s1   <= ip_addr;
			mac_s1  <= new_mac;
		end
	end

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_any  = 1'b0;
		free_any = 1'b0;
		for (int i = 0; i < arc_pkg::ENTRIES; i++)
			hit[i] = valid_q[i] && (ip_q[i] == ip_s1);
		// scan downwards so the lowest-numbered slot wins
		for (int i = arc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = arc_pkg::IDX_W'(i);
				hit_any = 1'b1;
			end
			if (!valid_q[i]) begin
				free_idx = arc_pkg::IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (func_s1)
				arc_pkg::OP_INSERT: begin
					if (!hit_any && free_any) begin
						valid_q[free_idx] <= 1'b1;
						count_q <= count_q + arc_pkg::CNT_W'(1);
					end
				end
				arc_pkg::OP_CLEAR: begin
					valid_q <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// entry payload is only meaningful behind its valid bit
	always_ff @(posedge clk) begin
		if (cmd.exec && func_s1 == arc_pkg::OP_INSERT) begin
			if (hit_any) begin
				mac_q[hit_idx] <= mac_s1;
			end else if (free_any) begin
				ip_q[free_idx]  <= ip_s1;
				mac_q[free_idx] <= mac_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= arc_pkg::ST_OK;
			found_q  <= '0;
			case (func_s1)
				arc_pkg::OP_LOOKUP: begin
					if (hit_any)
						found_q <= mac_q[hit_idx];
					else
						status_q <= arc_pkg::ST_NOT_FOUND;
				end
				arc_pkg::OP_INSERT: begin
					if (!hit_any && !free_any)
						status_q <= arc_pkg::ST_FULL;
				end
				default: begin
				end
			endcase
		end
	end

	assign status      = status_q;
	assign found_mac   = found_q;
	assign valid_count = arc_pkg::sat_count(count_q);

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == arc_pkg::CNT_W'($countones(valid_q)))
		else $error("valid count out of step with valid bits");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && func_s1 == arc_pkg::OP_CLEAR) |=> (valid_q == '0))
		else $error("clear left valid entries");

	a_no_duplicate_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0(hit))
		else $error("key present in more than one slot");

endmodule

// ===== rtl/address_resolution_cache.sv =====
// Top level of the address resolution cache.
// Joins the arc_ctrl sequencer to the arc_datapath table.
// Depends on arc_pkg, arc_ctrl, arc_datapath.

// Fully associative IPv4-to-MAC table of arc_pkg::ENTRIES slots (16), held in
// flip-flops and cleared at once by reset or a clear transaction. A transaction
// is taken when start is high and busy is low; busy is then high for one cycle
// while all slots are compared in parallel and the table is updated, and the
// result appears with done high in the following cycle, when the next start
// may already be taken. No start is taken while busy is high, as set by the
// capture/execute sequence of the controller. The result is shown for that
// single cycle only and the receiver cannot hold it off; status, found_mac and
// valid_count keep their values until the next result.
module address_resolution_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] ip_addr,
	input  logic [47:0] new_mac,
	output logic        done,
	output logic [1:0]  status,
	output logic [47:0] found_mac,
	output logic [4:0]  valid_count
);

	arc_pkg::arc_cmd_t cmd;

	arc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	arc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.ip_addr     (ip_addr),
		.new_mac     (new_mac),
		.status      (status),
		.found_mac   (found_mac),
		.valid_count (valid_count)
	);

endmodule

// ===== dv/arc_checker.sv =====
// Checker for the address resolution cache: watches the command and result
// channels, keeps its own copy of the table and compares every result.
// Depends on arc_pkg.
module arc_checker
	import arc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] ip_addr,
	input  logic [47:0] new_mac,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [47:0] found_mac,
	input  logic [4:0]  valid_count,
	output int          fail_count,
	output int          pending,
	output int          replies_checked,
	output int          lookup_hits,
	output int          full_refusals
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] mac;
		logic [4:0]  count;
	} arc_reply_t;

	arc_reply_t  replies_due[$];
	logic        tbl_valid[ENTRIES];
	logic [31:0] tbl_ip[ENTRIES];
	logic [47:0] tbl_mac[ENTRIES];

	initial begin
		fail_count      = 0;
		pending         = 0;
		replies_checked = 0;
		lookup_hits     = 0;
		full_refusals   = 0;
	end

	task automatic wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_ip[i]    = '0;
			tbl_mac[i]   = '0;
		end
	endtask

	// apply one transaction to the shadow table and work out its reply
	task automatic resolve_binding(input logic [1:0] op, input logic [31:0] key,
			input logic [47:0] hw, output arc_reply_t r);
		int hit;
		int free_slot;
		int n;
		hit       = -1;
		free_slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_ip[i] == key && hit < 0)
				hit = i;
			if (!tbl_valid[i] && free_slot < 0)
				free_slot = i;
		end
		r.status = ST_OK;
		r.mac    = '0;
		case (op)
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.mac = tbl_mac[hit];
					lookup_hits++;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			OP_INSERT: begin
				if (hit >= 0) begin
					tbl_mac[hit] = hw;
				end else if (free_slot >= 0) begin
					tbl_valid[free_slot] = 1'b1;
					tbl_ip[free_slot]    = key;
					tbl_mac[free_slot]   = hw;
				end else begin
					r.status = ST_FULL;
					full_refusals++;
				end
			end
			OP_CLEAR: wipe_table();
			default: ;
		endcase
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i])
				n++;
		r.count = (n > COUNT_MAX) ? 5'(COUNT_MAX) : 5'(n);
	endtask

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		arc_reply_t due;
		arc_reply_t got;
		if (!arst_n) begin
			wipe_table();
			replies_due.delete();
			pending <= 0;
		end else begin
			// a result can leave in the same cycle as a new acceptance, so settle it first
			if (done) begin
				got = '{status, found_mac, valid_count};
				if (replies_due.size() == 0) begin
					note_failure($sformatf("result with none due: status %0d mac %h count %0d",
						got.status, got.mac, got.count));
				end else begin
					due = replies_due.pop_front();
					replies_checked++;
					if (got.status !== due.status || got.mac !== due.mac ||
							got.count !== due.count)
						note_failure($sformatf(
							"exp status %0d mac %h count %0d, got status %0d mac %h count %0d",
							due.status, due.mac, due.count, got.status, got.mac, got.count));
				end
			end
			if (start && !busy) begin
				resolve_binding(func, ip_addr, new_mac, due);
				replies_due.push_back(due);
			end
			pending <= replies_due.size();
		end
	end

endmodule

// ===== dv/address_resolution_cache_tb.sv =====
// Testbench top for the address resolution cache: clock, reset, stimulus,
// watchdog and verdict. Checking is left to arc_checker.
// Depends on arc_pkg, arc_checker, address_resolution_cache.
module address_resolution_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arc_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 1320;
	localparam int         KEY_POOL     = 24;
	localparam int         STALL_LIMIT  = 1000;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic [1:0]  func    = OP_LOOKUP;
	logic [31:0] ip_addr = '0;
	logic [47:0] new_mac = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [47:0] found_mac;
	logic [4:0]  valid_count;

	int          fail_count;
	int          pending;
	int          replies_checked;
	int          lookup_hits;
	int          full_refusals;
	int          idle_pct     = 0;
	int          stall_cycles = 0;
	logic [31:0] key_pool[KEY_POOL];

	always #5 clk = ~clk;

	address_resolution_cache u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.ip_addr     (ip_addr),
		.new_mac     (new_mac),
		.done        (done),
		.status      (status),
		.found_mac   (found_mac),
		.valid_count (valid_count)
	);

	arc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.ip_addr         (ip_addr),
		.new_mac         (new_mac),
		.done            (done),
		.status          (status),
		.found_mac       (found_mac),
		.valid_count     (valid_count),
		.fail_count      (fail_count),
		.pending         (pending),
		.replies_checked (replies_checked),
		.lookup_hits     (lookup_hits),
		.full_refusals   (full_refusals)
	);

	// hold start until the block takes the transaction; busy read here is the
	// value before the edge
	task automatic issue(input logic [1:0] op, input logic [31:0] key,
			input logic [47:0] hw);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		func    <= op;
		ip_addr <= key;
		new_mac <= hw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom, $urandom});
	endfunction

	// mostly keys from a small pool so that hits, updates and a full table occur
	task automatic issue_random();
		int          pick;
		logic [1:0]  op;
		logic [31:0] key;
		pick = $urandom_range(999);
		if (pick < 440)
			op = OP_LOOKUP;
		else if (pick < 940)
			op = OP_INSERT;
		else if (pick < 955)
			op = OP_CLEAR;
		else
			op = OP_UNUSED;
		if ($urandom_range(99) < 8)
			key = $urandom;
		else
			key = key_pool[$urandom_range(KEY_POOL - 1)];
		issue(op, key, rand_mac());
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase_idle[4];
		phase_idle = '{0, 67, 0, 17};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_LOOKUP, 32'h0, 48'h0);
		issue(OP_INSERT, 32'h0, 48'h0);
		issue(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		issue(OP_LOOKUP, 32'h0, 48'h0);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		issue(OP_INSERT, 32'h0, 48'hAAAA_AAAA_AAAA);
		issue(OP_LOOKUP, 32'h0, 48'h5555_5555_5555);
		issue(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		issue(OP_LOOKUP, 32'h5555_5555, 48'h0);
		issue(OP_CLEAR, 32'hAAAA_AAAA, 48'hFFFF_FFFF_FFFF);
		for (int k = 0; k < ENTRIES; k++)
			issue(OP_INSERT, {24'hC0A801, 8'(k)}, rand_mac());
		// table full: a new key is refused, an existing one still updates
		issue(OP_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
		issue(OP_INSERT, 32'hC0A8_0105, 48'hFFFF_FFFF_FFFF);
		issue(OP_LOOKUP, 32'hC0A8_0105, 48'h0);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			key_pool[0] = 32'h0;
			key_pool[1] = 32'hFFFF_FFFF;
			for (int k = 2; k < KEY_POOL; k++)
				key_pool[k] = $urandom;
			for (int i = 0; i < RANDOM_ITEMS / 4; i++)
				issue_random();
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d results over four pacing phases, all four op codes.",
			replies_checked);
		$display("Lookup hits: %0d, inserts refused on a full table: %0d, failures: %0d.",
			lookup_hits, full_refusals, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			if (pending != 0)
				$display("%0d results never arrived", pending);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
